FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ITRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never occurs outside reset.
`define ITRA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: src/itra_pkg.sv
package itra_pkg;

  localparam int VALUE_BITS = 64;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int STEP_BITS  = 8;

  typedef logic [RADIX_W-1:0] radix_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  localparam radix_t RADIX_MIN  = 5'd3;
  localparam radix_t RADIX_MAX  = 5'd16;
  localparam char_t  CHAR_MINUS = 8'h2d;
  localparam char_t  CHAR_ZERO  = 8'h30;
  localparam char_t  CHAR_LOWER = 8'h61;
  localparam char_t  CHAR_UPPER = 8'h41;
  localparam digit_t DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic   done;
    logic   zero;
    digit_t rem;
  } div_stat_t;

  function automatic char_t digit_char(input digit_t d, input logic lower);
    char_t ext;
    ext = {4'h0, d};
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + ext;
    end else if (lower) begin
      return CHAR_LOWER + ext - char_t'(DIGIT_TEN);
    end else begin
      return CHAR_UPPER + ext - char_t'(DIGIT_TEN);
    end
  endfunction

endpackage

FILE: src/itra_div.sv
`include "assert_macros.svh"

module itra_div #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  itra_pkg::radix_t       radix,
  output logic [VALUE_WIDTH-1:0] quotient,
  output itra_pkg::div_stat_t    stat
);
  import itra_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PW    = STEPS * STEP_BITS;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [PW-1:0] d;
  logic [PW-1:0] d_next;
  digit_t        r;
  digit_t        r_next;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  // While a run is busy, each cycle retires STEP_BITS quotient bits by restoring division.
  always_comb begin
    logic [RADIX_W-1:0] t;
    d_next = d;
    r_next = r;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r_next, d_next[PW-1]};
      d_next = {d_next[PW-2:0], 1'b0};
      if (t >= radix) begin
        d_next[0] = 1'b1;
        r_next = DIGIT_W'(t - radix);
      end else begin
        r_next = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d    <= PW'(dividend);
        r    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        d   <= d_next;
        r   <= r_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = d[VALUE_WIDTH-1:0];
  assign stat.done = done;
  assign stat.zero = (d == '0);
  assign stat.rem  = r;

  `ITRA_ASSERT(a_done_follows_busy, done |-> $past(busy), "Divider done without a run.")
  `ITRA_ASSERT_NEVER(a_start_while_busy, start && busy, "Divider restarted mid-run.")

endmodule

FILE: src/itra_stack.sv
`include "assert_macros.svh"

module itra_stack #(
  parameter int DEPTH = 41
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  input  itra_pkg::digit_t           din,
  output itra_pkg::digit_t           top,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import itra_pkg::*;

  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  digit_t          stk [DEPTH];
  logic [IDXW-1:0] wr_idx;
  logic [IDXW-1:0] rd_idx;

  assign wr_idx = IDXW'(count);
  assign rd_idx = IDXW'(count - CNTW'(2));

  // The top entry is kept in a register; a pop reloads it from the memory.
  always_ff @(posedge clk) begin
    if (push) begin
      stk[wr_idx] <= din;
      top         <= din;
    end else if (pop && (count > CNTW'(1))) begin
      top <= stk[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count + CNTW'(1);
    end else if (pop) begin
      count <= count - CNTW'(1);
    end
  end

  `ITRA_ASSERT_NEVER(a_push_full, push && (count == CNTW'(DEPTH)), "Digit stack overflow.")
  `ITRA_ASSERT_NEVER(a_pop_empty, pop && (count == '0), "Digit stack underflow.")

endmodule

FILE: src/integer_to_radix_ascii.sv
// Integer to radix ASCII converter.
// The input channel (item_valid, item_stall) takes a value, a radix clamped to
// 3 to 16, an unsigned flag and a letter-case flag. The output channel
// (char_valid, char_stall) returns the text one character per transaction,
// a minus sign first for a negative signed value, then the digits most
// significant first; last_char marks the final character.
// One divider unit retires 8 quotient bits per cycle while it runs; each
// digit is one full division of the running quotient by the radix, and the
// remainders are stacked. After the last division the state register is set
// first and the output register then takes the first character; then one
// character per cycle follows while char_stall is low. A 64-bit value in
// radix 3 needs 41 digits.
// item_stall is high from acceptance until the last character is loaded into
// the output register, so a new transaction can be taken while that final
// character still waits. When char_stall is high the output register holds
// its character and the sequencer waits to load the next. Reset empties the
// output register and returns the sequencer to idle; no clearing pass.
`include "assert_macros.svh"

module integer_to_radix_ascii #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_CHARS   = 42
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [itra_pkg::VALUE_BITS-1:0]     value,
  input  itra_pkg::radix_t                    radix,
  input  logic                                treat_unsigned,
  input  logic                                lower_case,
  output logic                                char_valid,
  input  logic                                char_stall,
  output itra_pkg::char_t                     character,
  output logic                                last_char
);
  import itra_pkg::*;

  localparam int DEPTH = MAX_CHARS - 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t                 state;
  radix_t                 rad;
  logic                   neg;
  logic                   lower;
  logic                   accept;
  logic                   out_free;
  logic                   finish;
  logic                   div_start;
  logic                   push;
  logic                   pop;
  logic                   neg_in;
  radix_t                 rad_in;
  logic [VALUE_WIDTH-1:0] n_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  div_stat_t              stat;
  digit_t                 stk_top;
  logic [CNTW-1:0]        stk_count;

  always_comb begin
    n_in   = value[VALUE_WIDTH-1:0];
    neg_in = !treat_unsigned && n_in[VALUE_WIDTH-1];
    mag_in = neg_in ? (~n_in + VALUE_WIDTH'(1)) : n_in;
    if (radix < RADIX_MIN) begin
      rad_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      rad_in = RADIX_MAX;
    end else begin
      rad_in = radix;
    end
  end

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !char_valid || !char_stall;
  assign finish     = stat.zero || (stk_count == CNTW'(DEPTH - 1));
  assign push       = (state == S_DIV) && stat.done;
  assign pop        = (state == S_EMIT) && out_free;
  assign div_start  = accept || (push && !finish);
  assign dividend   = (state == S_IDLE) ? mag_in : quotient;

  itra_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .radix    (rad),
    .quotient (quotient),
    .stat     (stat)
  );

  itra_stack #(
    .DEPTH(DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .din   (stat.rem),
    .top   (stk_top),
    .count (stk_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_free) begin
            char_valid <= 1'b0;
          end
          if (accept) begin
            rad   <= rad_in;
            neg   <= neg_in;
            lower <= lower_case;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (out_free) begin
            char_valid <= 1'b0;
          end
          if (stat.done && finish) begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            char_valid <= 1'b1;
            character  <= CHAR_MINUS;
            last_char  <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            char_valid <= 1'b1;
            character  <= digit_char(stk_top, lower);
            last_char  <= (stk_count == CNTW'(1));
            if (stk_count == CNTW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ITRA_ASSERT(a_last_empties_stack, (pop && stk_count == CNTW'(1)) |=> (stk_count == '0),
               "Digits left after the last character.")
  `ITRA_ASSERT(a_push_only_dividing, push |-> $past(state == S_DIV),
               "Digit pushed outside a conversion.")

endmodule

FILE: dv/integer_to_radix_ascii_checker.sv
`timescale 1ns / 100ps

module integer_to_radix_ascii_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic [itra_pkg::VALUE_BITS-1:0] value,
  input  itra_pkg::radix_t                radix,
  input  logic                            treat_unsigned,
  input  logic                            lower_case,
  input  logic                            char_valid,
  input  logic                            char_stall,
  input  itra_pkg::char_t                 character,
  input  logic                            last_char,
  output int                              errors,
  output int                              pending
);
  import itra_pkg::*;

  localparam int TEXT_MAX = 42;

  typedef struct packed {
    char_t code;
    logic  is_last;
  } text_char_t;

  text_char_t expected_text[$];

  function automatic void render_text(input logic [VALUE_BITS-1:0] number,
                                      input radix_t base_in, input logic no_sign,
                                      input logic lower);
    logic [VALUE_BITS-1:0] magnitude;
    logic [VALUE_BITS-1:0] base;
    digit_t d;
    char_t digits[$];
    logic negative;
    text_char_t entry;
    if (base_in < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base_in > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = base_in;
    end
    negative = !no_sign && number[VALUE_BITS-1];
    magnitude = negative ? -number : number;
    do begin
      d = digit_t'(magnitude % base);
      if (d < DIGIT_TEN) begin
        digits.push_front(CHAR_ZERO + char_t'(d));
      end else begin
        digits.push_front((lower ? CHAR_LOWER : CHAR_UPPER) + char_t'(d - DIGIT_TEN));
      end
      magnitude = magnitude / base;
    end while (magnitude != 0 && digits.size() < TEXT_MAX - 1);
    if (negative) begin
      digits.push_front(CHAR_MINUS);
    end
    foreach (digits[k]) begin
      entry.code = digits[k];
      entry.is_last = (k == digits.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin : monitor
    text_char_t head;
    if (rst) begin
      expected_text.delete();
      errors = 0;
    end else begin
      if (char_valid && !char_stall) begin
        if (expected_text.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, actual %h last %b",
                   $time, character, last_char);
        end else begin
          head = expected_text.pop_front();
          if (character !== head.code) begin
            errors++;
            $display("%0t: character mismatch, expected %h, actual %h",
                     $time, head.code, character);
          end
          if (last_char !== head.is_last) begin
            errors++;
            $display("%0t: last_char mismatch, expected %b, actual %b",
                     $time, head.is_last, last_char);
          end
        end
      end
      if (item_valid && !item_stall) begin
        render_text(value, radix, treat_unsigned, lower_case);
      end
    end
    pending = expected_text.size();
  end

endmodule

FILE: dv/integer_to_radix_ascii_tb.sv
`timescale 1ns / 100ps

module integer_to_radix_ascii_tb;
  import itra_pkg::*;

  localparam int RANDOM_ITEMS = 200;
  localparam int CALM_ITEMS   = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  logic [VALUE_BITS-1:0] value;
  radix_t                radix;
  logic                  treat_unsigned;
  logic                  lower_case;
  logic                  char_valid;
  logic                  char_stall;
  char_t                 character;
  logic                  last_char;
  int                    errors;
  int                    pending;
  int                    items_sent = 0;
  int                    chars_seen = 0;
  int                    idle_cycles = 0;
  logic                  calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  integer_to_radix_ascii dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .value(value), .radix(radix), .treat_unsigned(treat_unsigned),
    .lower_case(lower_case),
    .char_valid(char_valid), .char_stall(char_stall),
    .character(character), .last_char(last_char)
  );

  integer_to_radix_ascii_checker checker_inst (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .value(value), .radix(radix), .treat_unsigned(treat_unsigned),
    .lower_case(lower_case),
    .char_valid(char_valid), .char_stall(char_stall),
    .character(character), .last_char(last_char),
    .errors(errors), .pending(pending)
  );

  task automatic offer(input logic [VALUE_BITS-1:0] v, input radix_t r, input logic u,
                       input logic l);
    if (!calm && (items_sent / 16) % 3 != 2 && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    value <= v;
    radix <= r;
    treat_unsigned <= u;
    lower_case <= l;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  initial begin : stimulus
    logic [VALUE_BITS-1:0] v;
    radix_t r;
    int kind;
    rst <= 1'b1;
    item_valid <= 1'b0;
    value <= '0;
    radix <= RADIX_MIN;
    treat_unsigned <= 1'b0;
    lower_case <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    offer(64'd0, 5'd10, 1'b0, 1'b0);
    offer(64'd0, 5'd3, 1'b1, 1'b1);
    offer('1, 5'd10, 1'b0, 1'b0);
    offer('1, 5'd3, 1'b1, 1'b0);
    offer(64'h8000_0000_0000_0000, 5'd3, 1'b0, 1'b0);
    offer(64'h8000_0000_0000_0000, 5'd16, 1'b0, 1'b1);
    offer(64'h8000_0000_0000_0000, 5'd16, 1'b1, 1'b0);
    offer(64'h7FFF_FFFF_FFFF_FFFF, 5'd16, 1'b0, 1'b0);
    offer(64'hFEDC_BA98_7654_3210, 5'd16, 1'b1, 1'b1);
    offer(64'hFEDC_BA98_7654_3210, 5'd16, 1'b1, 1'b0);
    offer(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0, 1'b1);
    offer(64'd255, 5'd16, 1'b0, 1'b0);
    offer(64'd100, 5'd0, 1'b0, 1'b0);
    offer(64'd100, 5'd1, 1'b1, 1'b0);
    offer(64'd100, 5'd2, 1'b0, 1'b1);
    offer(64'h00AB_CDEF, 5'd17, 1'b0, 1'b1);
    offer(64'h00AB_CDEF, 5'd31, 1'b1, 1'b0);
    offer(-64'sd1234567, 5'd7, 1'b0, 1'b0);
    offer(64'd35, 5'd12, 1'b0, 1'b1);
    offer(64'h1_2345_6789, 5'd13, 1'b1, 1'b0);
    offer(64'd9, 5'd9, 1'b0, 1'b0);
    offer(64'd14, 5'd15, 1'b0, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: v = {$urandom, $urandom};
        3: v = 64'($urandom_range(0, 1000));
        4: v = -64'($urandom_range(1, 1000));
        5: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 15));
        6: v = '1 - 64'($urandom_range(0, 15));
        7: v = 64'd1 << $urandom_range(0, 63);
        default: v = {32'd0, $urandom};
      endcase
      if ($urandom_range(0, 9) == 0) begin
        r = radix_t'($urandom_range(0, 31));
      end else begin
        r = radix_t'($urandom_range(3, 16));
      end
      offer(v, r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Converted %0d numbers into %0d characters over radices 0 to 31,",
             items_sent, chars_seen);
    $display("signed and unsigned, both letter cases, with one long output hold-off.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : receive_side
    int hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    char_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && char_valid && !char_stall) begin
        chars_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (!held && chars_seen >= 100) begin
        held = 1'b1;
        char_stall <= 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (!calm && (chars_seen / 50) % 3 != 2 && $urandom_range(0, 3) == 0) begin
        char_stall <= 1'b1;
        hold_left = $urandom_range(1, 8) - 1;
      end else begin
        char_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (char_valid && !char_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: files.f
+incdir+src
src/itra_pkg.sv
src/itra_div.sv
src/itra_stack.sv
src/integer_to_radix_ascii.sv
dv/integer_to_radix_ascii_checker.sv
dv/integer_to_radix_ascii_tb.sv
